FILE: hw/rtl/block_bitmap_allocator_defines.svh
// Assertion helpers for the bitmap allocator. Each macro expects clk and rst_n in scope.
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bba_pkg.sv
package bba_pkg;

    localparam int NBLOCKS_DEF   = 4096;
    localparam int WORD_BITS_DEF = 32;

    localparam int MODE_W     = 2;
    localparam int BN_W       = 12;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int LANE_MAX_W = 6;

    localparam logic [CFG_W-1:0]     TOTAL_RESET   = 13'd4096;
    localparam logic [CFG_W-1:0]     RESERVED_RESET = 13'd0;
    localparam logic [COUNT_W-1:0]   COUNT_CEIL    = 13'h1FFF;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_FORMAT = 2'd0,
        MODE_ALLOC  = 2'd1,
        MODE_FREE   = 2'd2,
        MODE_TEST   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FMT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ACC_RD,
        ST_ACC_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  found;
        logic [LANE_MAX_W-1:0] lane;
    } find_t;

endpackage

FILE: hw/rtl/bba_if.sv
interface bba_req_if;
    logic                        valid;
    logic                        ready;
    logic [bba_pkg::MODE_W-1:0]  mode;
    logic [bba_pkg::BN_W-1:0]    block_number;

    modport source (output valid, output mode, output block_number, input ready);
    modport sink (input valid, input mode, input block_number, output ready);
endinterface

interface bba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::STATUS_W-1:0] status;
    logic [bba_pkg::BN_W-1:0]     allocated_block;
    logic                         bit_value;
    logic [bba_pkg::COUNT_W-1:0]  free_count;

    modport source (output valid, output status, output allocated_block, output bit_value,
                    output free_count, input ready);
    modport sink (input valid, input status, input allocated_block, input bit_value,
                  input free_count, output ready);
endinterface

FILE: hw/rtl/bba_ram.sv
module bba_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/bba_find.sv
module bba_find #(
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF,
    parameter int AW        = 7
) (
    input  logic [AW-1:0]             waddr,
    input  logic [bba_pkg::CFG_W-1:0] bound,
    input  logic [WORD_BITS-1:0]      data,
    output logic [WORD_BITS-1:0]      mask,
    output bba_pkg::find_t            res
);

    import bba_pkg::*;

    localparam int LW = $clog2(WORD_BITS);
    localparam int CW = ((AW + LW) > CFG_W ? AW + LW : CFG_W) + 1;

    logic [CW-1:0]        base;
    logic [CW-1:0]        bnd;
    logic [CW-1:0]        diff;
    logic [WORD_BITS-1:0] cand;

    assign base = CW'(waddr) << LW;
    assign bnd  = CW'(bound);
    assign diff = bnd - base;

    // A lane takes part only if its block number lies below the bound.
    always_comb
    begin
        for (int k = 0; k < WORD_BITS; k++)
        begin
            mask[k] = (bnd > base) && (diff > CW'(k));
        end
    end

    assign cand = ~data & mask;

    always_comb
    begin
        res.found = |cand;
        res.lane  = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                res.lane = LANE_MAX_W'(k);
            end
        end
    end

endmodule

FILE: hw/rtl/block_bitmap_allocator.sv
// First-fit block allocator over a used/free bitmap held in a single-port-read RAM of
// NBLOCKS/WORD_BITS words, with a free block counter. A small sequencer moves each request
// through its steps, so one request is in progress at a time, while a finished result waits
// in the output register and the next request is already taken. Free and test read the
// addressed bitmap word and then check it, or finish at once when the block number lies
// outside the managed limit; format writes every bitmap word once; allocate reads and checks
// one word after another up to the first word with a free block inside the managed limit,
// and stops with no free status when the words inside the limit run out; an allocate with
// a zero free count finishes at once. After reset the bitmap reads as all free through one
// valid bit per word, so there is no clearing pass. WORD_BITS must be a power of two.
`include "block_bitmap_allocator_defines.svh"

module block_bitmap_allocator #(
    parameter int NBLOCKS   = bba_pkg::NBLOCKS_DEF,
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bba_req_if.sink                       req,
    bba_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]     cfg_data
);

    import bba_pkg::*;

    localparam int MAP_WORDS = (NBLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
    localparam int LW        = $clog2(WORD_BITS);
    localparam int CW        = ((AW + LW) > CFG_W ? AW + LW : CFG_W) + 1;
    localparam int CNT_W     = $clog2(NBLOCKS + 1) > COUNT_W ? $clog2(NBLOCKS + 1) : COUNT_W;

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [BN_W-1:0]      bn_reg, bn_next;
    logic [AW:0]          waddr_reg, waddr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CFG_W-1:0]     total_reg;
    logic [CFG_W-1:0]     resv_reg;

    status_t              res_status_reg, res_status_next;
    logic [BN_W-1:0]      res_block_reg, res_block_next;
    logic                 res_bit_reg, res_bit_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    status_t              rsp_status_reg;
    logic [BN_W-1:0]      rsp_block_reg;
    logic                 rsp_bit_reg;
    logic [COUNT_W-1:0]   rsp_count_reg;

    logic [MAP_WORDS-1:0] vld_reg;
    logic                 vld_q_reg;

    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_q;
    logic [WORD_BITS-1:0] rd_word;

    logic [CFG_W-1:0]     limit;
    logic [CFG_W-1:0]     resv_eff;
    logic [CFG_W-1:0]     bound;
    logic [CW-1:0]        base;
    logic [CW-1:0]        bn_word_full;
    logic [AW-1:0]        bn_word;
    logic [LW-1:0]        bn_lane;
    logic                 bn_bit;
    logic [CW-1:0]        grant;
    logic [WORD_BITS-1:0] fmt_mask;
    find_t                find_res;
    logic [LW-1:0]        find_lane;

    logic                 accept;
    logic                 in_range_bad;
    logic                 fmt_last;
    logic                 scan_end;
    logic                 out_load;
    logic                 alloc_hit;

    assign limit    = (32'(total_reg) > 32'(NBLOCKS)) ? CFG_W'(NBLOCKS) : total_reg;
    assign resv_eff = (resv_reg > limit) ? limit : resv_reg;
    assign bound    = (state_reg == ST_FMT) ? resv_eff : limit;

    assign base         = CW'(waddr_reg) << LW;
    assign bn_word_full = CW'(bn_reg) >> LW;
    assign bn_word      = bn_word_full[AW-1:0];
    assign bn_lane      = bn_reg[LW-1:0];
    assign rd_word      = vld_q_reg ? mem_q : '0;
    assign bn_bit       = rd_word[bn_lane];
    assign find_lane    = find_res.lane[LW-1:0];
    assign grant        = base + CW'(find_lane);

    assign accept       = req.valid && req.ready;
    assign in_range_bad = CFG_W'(req.block_number) >= limit;
    assign fmt_last     = waddr_reg == (AW + 1)'(MAP_WORDS - 1);
    assign scan_end     = base >= CW'(limit);
    assign out_load     = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);
    assign alloc_hit    = (state_reg == ST_SCAN_CHK) && find_res.found;

    assign req.ready           = state_reg == ST_IDLE;
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.allocated_block = rsp_block_reg;
    assign rsp.bit_value       = rsp_bit_reg;
    assign rsp.free_count      = rsp_count_reg;

    bba_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    bba_find #(
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_find (
        .waddr (waddr_reg[AW-1:0]),
        .bound (bound),
        .data  (rd_word),
        .mask  (fmt_mask),
        .res   (find_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_t'(req.mode))
                        MODE_FORMAT: state_next = ST_FMT;
                        MODE_ALLOC:  state_next = (cnt_reg == '0) ? ST_DONE : ST_SCAN_RD;
                        MODE_FREE,
                        MODE_TEST:   state_next = in_range_bad ? ST_DONE : ST_ACC_RD;
                    endcase
                end
            end
            ST_FMT:      state_next = fmt_last ? ST_DONE : ST_FMT;
            ST_SCAN_RD:  state_next = scan_end ? ST_DONE : ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = find_res.found ? ST_DONE : ST_SCAN_RD;
            ST_ACC_RD:   state_next = ST_ACC_CHK;
            ST_ACC_CHK:  state_next = ST_DONE;
            ST_DONE:     state_next = out_load ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        bn_next         = bn_reg;
        waddr_next      = waddr_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_bit_next    = res_bit_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = waddr_reg[AW-1:0];
        mem_raddr       = waddr_reg[AW-1:0];
        mem_wdata       = fmt_mask;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = mode_t'(req.mode);
                    bn_next         = req.block_number;
                    waddr_next      = '0;
                    res_status_next = STAT_OK;
                    res_block_next  = req.block_number;
                    res_bit_next    = 1'b0;
                    unique case (mode_t'(req.mode))
                        MODE_FORMAT:
                        begin
                        end
                        MODE_ALLOC:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = STAT_NO_FREE;
                            end
                        end
                        MODE_FREE,
                        MODE_TEST:
                        begin
                            if (in_range_bad)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                        end
                    endcase
                end
            end
            ST_FMT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = fmt_mask;
                waddr_next = waddr_reg + 1'b1;
                if (fmt_last)
                begin
                    cnt_next = CNT_W'(limit - resv_eff);
                end
            end
            ST_SCAN_RD:
            begin
                if (scan_end)
                begin
                    res_status_next = STAT_NO_FREE;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            ST_SCAN_CHK:
            begin
                if (find_res.found)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = rd_word | (WORD_BITS'(1) << find_lane);
                    cnt_next       = cnt_reg - 1'b1;
                    res_block_next = grant[BN_W-1:0];
                    res_bit_next   = 1'b1;
                end
                else
                begin
                    waddr_next = waddr_reg + 1'b1;
                end
            end
            ST_ACC_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = bn_word;
            end
            ST_ACC_CHK:
            begin
                mem_waddr = bn_word;
                mem_wdata = rd_word & ~(WORD_BITS'(1) << bn_lane);
                if (mode_reg == MODE_FREE)
                begin
                    res_bit_next = 1'b0;
                    if (bn_bit)
                    begin
                        mem_we = 1'b1;
                        if (cnt_reg < CNT_W'(COUNT_CEIL))
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    res_bit_next = bn_bit;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            waddr_reg     <= '0;
            cnt_reg       <= CNT_W'(NBLOCKS);
            total_reg     <= TOTAL_RESET;
            resv_reg      <= RESERVED_RESET;
            rsp_valid_reg <= 1'b0;
            vld_reg       <= '0;
            vld_q_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            waddr_reg     <= waddr_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOTAL:    total_reg <= cfg_data;
                    CFG_RESERVED: resv_reg  <= cfg_data;
                    default:      total_reg <= total_reg;
                endcase
            end
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                vld_q_reg <= vld_reg[mem_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        bn_reg         <= bn_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_bit_reg    <= res_bit_next;
        if (out_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_block_reg  <= res_block_reg;
            rsp_bit_reg    <= res_bit_reg;
            rsp_count_reg  <= cnt_reg[COUNT_W-1:0];
        end
    end

    `BBA_ASSERT_SAME(a_rsp_done, $rose(rsp_valid_reg), $past(out_load), "stray result")
    `BBA_ASSERT_NEXT(a_alloc_count, alloc_hit, cnt_reg == $past(cnt_reg) - 1'b1, "no decrement")
    `BBA_ASSERT_SAME(a_acc_range, state_reg == ST_ACC_CHK, CFG_W'(bn_reg) < limit, "bad address")

endmodule
